@@ rtl/lrpg_pkg.sv @@
package lrpg_pkg;

    localparam int DIMENSIONS_DEFAULT    = 10;
    localparam int FRACTION_BITS_DEFAULT = 32;
    localparam int MAX_DIMENSIONS        = 10;
    localparam int TABLE_ROWS            = 19;
    localparam int ROW_W                 = 5;
    localparam int MOD_W                 = 30;
    localparam int REQ_W                 = 30;
    localparam int INDEX_W               = 30;
    localparam int DIM_W                 = 4;
    localparam int COORD_W               = 32;
    localparam int PROD_W                = MOD_W + INDEX_W + 1;

    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_GENERATE = 1'b1;

    function automatic logic [MOD_W-1:0] row_modulus(input logic [ROW_W-1:0] row);
        logic [MOD_W-1:0] n;
        case (row)
            5'd0:  n = 30'd10007;
            5'd1:  n = 30'd20011;
            5'd2:  n = 30'd30011;
            5'd3:  n = 30'd50021;
            5'd4:  n = 30'd100003;
            5'd5:  n = 30'd200003;
            5'd6:  n = 30'd300017;
            5'd7:  n = 30'd400009;
            5'd8:  n = 30'd500009;
            5'd9:  n = 30'd750019;
            5'd10: n = 30'd1000003;
            5'd11: n = 30'd1500007;
            5'd12: n = 30'd2000003;
            5'd13: n = 30'd3000017;
            5'd14: n = 30'd4000037;
            5'd15: n = 30'd6000011;
            5'd16: n = 30'd8000009;
            5'd17: n = 30'd10000019;
            default: n = 30'd1000000000;
        endcase
        return n;
    endfunction

    // generator coefficient for dimension d (0..9) of a row
    function automatic logic [MOD_W-1:0] row_coef(input logic [ROW_W-1:0] row,
                                                  input logic [DIM_W-1:0] d);
        logic [MOD_W-1:0] c [0:6];
        logic [MOD_W-1:0] a;
        c[0] = '0; c[1] = '0; c[2] = '0; c[3] = '0; c[4] = '0; c[5] = '0; c[6] = '0;
        case (row)
            5'd0:  begin c = '{30'd1905, 30'd6491, 30'd6710, 30'd3611, 30'd4146,
                              30'd2607, 30'd2863}; end
            5'd1:  begin c = '{30'd7191, 30'd2057, 30'd3758, 30'd8928, 30'd5960,
                              30'd14809, 30'd12988}; end
            5'd2:  begin c = '{30'd13167, 30'd26353, 30'd2769, 30'd26069, 30'd14716,
                              30'd14556, 30'd8606}; end
            5'd3:  begin c = '{30'd11281, 30'd7537, 30'd39218, 30'd32534, 30'd11977,
                              30'd5816, 30'd32765}; end
            5'd4:  begin c = '{30'd20285, 30'd68883, 30'd49739, 30'd25348, 30'd68757,
                              30'd93907, 30'd46351}; end
            5'd5:  begin c = '{30'd47369, 30'd188507, 30'd54145, 30'd156036, 30'd158419,
                              30'd37051, 30'd42494}; end
            5'd6:  begin c = '{30'd81575, 30'd103565, 30'd136172, 30'd101475, 30'd54078,
                              30'd262899, 30'd170731}; end
            5'd7:  begin c = '{30'd193141, 30'd206577, 30'd390670, 30'd296791, 30'd20804,
                              30'd14959, 30'd331221}; end
            5'd8:  begin c = '{30'd42535, 30'd193663, 30'd307439, 30'd182488, 30'd487373,
                              30'd37415, 30'd418387}; end
            5'd9:  begin c = '{30'd10525, 30'd522832, 30'd667416, 30'd625465, 30'd102362,
                              30'd332766, 30'd523439}; end
            5'd10: begin c = '{30'd417564, 30'd171019, 30'd163483, 30'd410620, 30'd615303,
                              30'd611111, 30'd188073}; end
            5'd11: begin c = '{30'd413996, 30'd388189, 30'd943278, 30'd1496508, 30'd434758,
                              30'd733031, 30'd985685}; end
            5'd12: begin c = '{30'd832685, 30'd1269182, 30'd1228431, 30'd532894, 30'd174792,
                              30'd458201, 30'd527381}; end
            5'd13: begin c = '{30'd368334, 30'd166765, 30'd2871452, 30'd407635, 30'd979274,
                              30'd1865572, 30'd2703215}; end
            5'd14: begin c = '{30'd72362, 30'd210611, 30'd92212, 30'd583028, 30'd681897,
                              30'd2974319, 30'd1680656}; end
            5'd15: begin c = '{30'd1323844, 30'd1723313, 30'd1392620, 30'd251332,
                              30'd5750225, 30'd908859, 30'd5328166}; end
            5'd16: begin c = '{30'd93973, 30'd6914802, 30'd3957321, 30'd907968, 30'd4380879,
                              30'd3879127, 30'd4791477}; end
            5'd17: begin c = '{30'd1833663, 30'd3609180, 30'd7252140, 30'd5522715,
                              30'd8914182, 30'd4652083, 30'd6262402}; end
            default: begin c = '{30'd1, 30'd1, 30'd1, 30'd1, 30'd1, 30'd1, 30'd1}; end
        endcase
        if (d < 4'd3) a = 30'd1;
        else if (d <= 4'd9) a = c[3'(d - 4'd3)];
        else a = 30'd1;
        return a;
    endfunction

endpackage

@@ rtl/lrpg_mulmod.sv @@
// (a * m) mod n, bit-serial: one multiplier bit per cycle, MSB first.
// acc <- 2*acc mod n, then + a mod n. Inputs a < n, m arbitrary 31 bits.
module lrpg_mulmod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lrpg_pkg::MOD_W-1:0]  coef,
    input  logic [lrpg_pkg::INDEX_W:0]  mult,
    input  logic [lrpg_pkg::MOD_W-1:0]  modulus,
    output logic                        busy,
    output logic                        done,
    output logic [lrpg_pkg::MOD_W-1:0]  residue
);
    localparam int MB  = lrpg_pkg::INDEX_W + 1;
    localparam int CW  = $clog2(MB + 1);

    logic [lrpg_pkg::MOD_W-1:0] acc_reg, acc_next;
    logic [MB-1:0]              m_reg, m_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [lrpg_pkg::MOD_W:0]   dbl, dsub, add, asub;
    logic [lrpg_pkg::MOD_W-1:0] dmod;

    always_comb
    begin
        dbl  = {acc_reg, 1'b0};
        dsub = dbl - {1'b0, modulus};
        dmod = (dbl >= {1'b0, modulus}) ? dsub[lrpg_pkg::MOD_W-1:0]
                                         : acc_reg << 1;
        add  = {1'b0, dmod} + (m_reg[MB-1] ? {1'b0, coef} : '0);
        asub = add - {1'b0, modulus};
        acc_next  = acc_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            m_next    = mult;
            cnt_next  = CW'(MB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (add >= {1'b0, modulus}) ? asub[lrpg_pkg::MOD_W-1:0]
                                                 : add[lrpg_pkg::MOD_W-1:0];
            m_next   = m_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        m_reg   <= m_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign residue = acc_reg;
endmodule

@@ rtl/lrpg_fracdiv.sv @@
// floor(r * 2^FRACTION_BITS / n) for r < n, restoring division, one bit per cycle.
module lrpg_fracdiv #(
    parameter int FRACTION_BITS = lrpg_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lrpg_pkg::MOD_W-1:0]  rem_in,
    input  logic [lrpg_pkg::MOD_W-1:0]  modulus,
    output logic                        busy,
    output logic                        done,
    output logic [FRACTION_BITS-1:0]    quotient
);
    localparam int CW = $clog2(FRACTION_BITS + 1);

    logic [lrpg_pkg::MOD_W-1:0] r_reg, r_next;
    logic [FRACTION_BITS-1:0]   q_reg, q_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [lrpg_pkg::MOD_W:0]   sh, diff;

    always_comb
    begin
        sh   = {r_reg, 1'b0};
        diff = sh - {1'b0, modulus};
        r_next    = r_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            r_next    = rem_in;
            q_next    = '0;
            cnt_next  = CW'(FRACTION_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= {1'b0, modulus})
            begin
                r_next = diff[lrpg_pkg::MOD_W-1:0];
                q_next = {q_reg[FRACTION_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = sh[lrpg_pkg::MOD_W-1:0];
                q_next = {q_reg[FRACTION_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

@@ rtl/lattice_rule_point_generator.sv @@
// Channel | valid    | stall    | payload
// in      | in_valid | in_stall | kind, point_index, dim_select, shift_value
// out     | out_valid| out_stall| dim_index, coordinate, last_coord
// cfg     | cfg_we   | -        | cfg_wdata (requested_points)
//
// Flow: a load transaction writes one shift entry if its dimension is in range. A generate
// transaction produces one coordinate per dimension; each coordinate passes through the
// serial modular product (start, 31 index bits, done) and then the serial fraction
// divider (start, FRACTION_BITS bits, done), then is handed over (ST_OUT) and the
// dimension advances (ST_NEXT) before the next coordinate starts.
// After a configuration write the row search holds in_stall until it settles on a row.
// Reset clears control state and the shift table at once (flip-flops).
// A stalled output holds its coordinate; the next coordinate waits behind it.
module lattice_rule_point_generator #(
    parameter int DIMENSIONS    = lrpg_pkg::DIMENSIONS_DEFAULT,
    parameter int FRACTION_BITS = lrpg_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lrpg_pkg::REQ_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [lrpg_pkg::INDEX_W-1:0]  point_index,
    input  logic [lrpg_pkg::DIM_W-1:0]    dim_select,
    input  logic [lrpg_pkg::COORD_W-1:0]  shift_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lrpg_pkg::DIM_W-1:0]    dim_index,
    output logic [lrpg_pkg::COORD_W-1:0]  coordinate,
    output logic                          last_coord
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_OUT  = 5'b01000,
        ST_NEXT = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [lrpg_pkg::REQ_W-1:0]      req_reg;
    logic [lrpg_pkg::ROW_W-1:0]      row_reg, row_next;
    logic                            searching;
    logic [lrpg_pkg::MOD_W-1:0]      n_reg;
    logic [lrpg_pkg::INDEX_W:0]      kp1_reg;
    logic [lrpg_pkg::DIM_W-1:0]      dim_reg, dim_next;
    logic [lrpg_pkg::DIM_W-1:0]      out_dim_reg;
    logic [FRACTION_BITS-1:0]        shift_reg [DIMENSIONS];
    logic                            out_valid_reg, out_valid_next;
    logic [lrpg_pkg::COORD_W-1:0]    coord_reg;
    logic [FRACTION_BITS-1:0]        sum;
    logic                            mul_start, mul_busy, mul_done;
    logic                            div_start, div_busy, div_done;
    logic [lrpg_pkg::MOD_W-1:0]      residue;
    logic [FRACTION_BITS-1:0]        quotient;
    logic                            in_acc, out_acc;

    // Hold the input while a point is in flight, the row search runs or cfg_we is high.
    assign searching = (row_reg < lrpg_pkg::ROW_W'(lrpg_pkg::TABLE_ROWS - 1))
                       && ({2'b0, lrpg_pkg::row_modulus(row_reg)} < {2'b0, req_reg});
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || searching || cfg_we;

    // Row search: advance one row a cycle while the request exceeds its modulus and the last row is not reached.
    always_comb
    begin
        row_next = row_reg;
        if (cfg_we)
            row_next = '0;
        else if (searching)
            row_next = row_reg + 1'b1;
    end

    // Start each unit once on entry; done drops it out of the state.
    assign mul_start = (state_reg == ST_MUL) && !mul_busy && !mul_done;
    assign div_start = (state_reg == ST_DIV) && !div_busy && !div_done;
    assign sum = shift_reg[dim_reg] + quotient;

    always_comb
    begin
        state_next     = state_reg;
        dim_next       = dim_reg;
        out_valid_next = out_valid_reg && !out_acc;
        case (state_reg)
            ST_IDLE:
                if (in_acc && kind == lrpg_pkg::KIND_GENERATE)
                begin
                    state_next = ST_MUL;
                    dim_next   = '0;
                end
            ST_MUL:
                if (mul_done)
                    state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_OUT;
            ST_OUT:
                if (!out_valid_reg || out_acc)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_NEXT;
                end
            ST_NEXT:
                if (dim_reg == lrpg_pkg::DIM_W'(DIMENSIONS - 1))
                    state_next = ST_IDLE;
                else
                begin
                    dim_next   = dim_reg + 1'b1;
                    state_next = ST_MUL;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            row_reg       <= '0;
            dim_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIMENSIONS; i++)
                shift_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            dim_reg       <= dim_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                req_reg <= cfg_wdata;
            if (in_acc && kind == lrpg_pkg::KIND_LOAD
                && {1'b0, dim_select} < 5'(DIMENSIONS))
                shift_reg[dim_select] <= shift_value[FRACTION_BITS-1:0];
        end
    end

    // Capture index+1 and modulus on input; hold the coordinate and its dimension together until accepted.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kp1_reg <= {1'b0, point_index} + 1'b1;
            n_reg   <= lrpg_pkg::row_modulus(row_reg);
        end
        if (state_reg == ST_OUT && (!out_valid_reg || out_acc))
        begin
            coord_reg   <= lrpg_pkg::COORD_W'(sum);
            out_dim_reg <= dim_reg;
        end
    end

    lrpg_mulmod u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .coef    (lrpg_pkg::row_coef(row_reg, dim_reg)),
        .mult    (kp1_reg),
        .modulus (n_reg),
        .busy    (mul_busy),
        .done    (mul_done),
        .residue (residue)
    );

    lrpg_fracdiv #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_in   (residue),
        .modulus  (n_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_valid  = out_valid_reg;
    assign coordinate = coord_reg;
    assign dim_index  = out_dim_reg;
    assign last_coord = (out_dim_reg == lrpg_pkg::DIM_W'(DIMENSIONS - 1));

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(coord_reg)
                                          && $stable(out_dim_reg)))
        else $error("stalled coordinate changed");
    a_units_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("units finished together");
endmodule

@@ verif/lattice_rule_point_checker.sv @@
module lattice_rule_point_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lrpg_pkg::REQ_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                kind,
    input  logic [lrpg_pkg::INDEX_W-1:0]        point_index,
    input  logic [lrpg_pkg::DIM_W-1:0]          dim_select,
    input  logic [lrpg_pkg::COORD_W-1:0]        shift_value,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [lrpg_pkg::DIM_W-1:0]          dim_index,
    input  logic [lrpg_pkg::COORD_W-1:0]        coordinate,
    input  logic                                last_coord,
    output int                                  error_count,
    output int                                  pending_coords,
    output int                                  coords_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NDIM = 10;
    localparam int NROWS = 19;

    typedef struct packed {
        logic [lrpg_pkg::DIM_W-1:0]   dim;
        logic [lrpg_pkg::COORD_W-1:0] coord;
        logic                         last;
    } coord_t;

    // modulus followed by coefficients for dimensions 3..9
    localparam logic [31:0] GEN_TABLE [0:NROWS-1][0:7] = '{
        '{10007, 1905, 6491, 6710, 3611, 4146, 2607, 2863},
        '{20011, 7191, 2057, 3758, 8928, 5960, 14809, 12988},
        '{30011, 13167, 26353, 2769, 26069, 14716, 14556, 8606},
        '{50021, 11281, 7537, 39218, 32534, 11977, 5816, 32765},
        '{100003, 20285, 68883, 49739, 25348, 68757, 93907, 46351},
        '{200003, 47369, 188507, 54145, 156036, 158419, 37051, 42494},
        '{300017, 81575, 103565, 136172, 101475, 54078, 262899, 170731},
        '{400009, 193141, 206577, 390670, 296791, 20804, 14959, 331221},
        '{500009, 42535, 193663, 307439, 182488, 487373, 37415, 418387},
        '{750019, 10525, 522832, 667416, 625465, 102362, 332766, 523439},
        '{1000003, 417564, 171019, 163483, 410620, 615303, 611111, 188073},
        '{1500007, 413996, 388189, 943278, 1496508, 434758, 733031, 985685},
        '{2000003, 832685, 1269182, 1228431, 532894, 174792, 458201, 527381},
        '{3000017, 368334, 166765, 2871452, 407635, 979274, 1865572, 2703215},
        '{4000037, 72362, 210611, 92212, 583028, 681897, 2974319, 1680656},
        '{6000011, 1323844, 1723313, 1392620, 251332, 5750225, 908859, 5328166},
        '{8000009, 93973, 6914802, 3957321, 907968, 4380879, 3879127, 4791477},
        '{10000019, 1833663, 3609180, 7252140, 5522715, 8914182, 4652083, 6262402},
        '{1000000000, 1, 1, 1, 1, 1, 1, 1}
    };

    logic [lrpg_pkg::REQ_W-1:0]   min_points;
    logic [lrpg_pkg::COORD_W-1:0] shifts [NDIM];
    coord_t                       coord_queue [$];

    function automatic logic [31:0] lattice_coord(input logic [lrpg_pkg::REQ_W-1:0] req,
                                                  input logic [31:0] shift,
                                                  input logic [lrpg_pkg::INDEX_W-1:0] k,
                                                  input int d);
        int          row;
        logic [63:0] n, a, r;
        row = NROWS - 1;
        for (int i = 0; i < NROWS - 1; i++)
            if (GEN_TABLE[i][0] >= req && row == NROWS - 1 && i < row)
            begin
                row = i;
                break;
            end
        n = GEN_TABLE[row][0];
        a = (d < 3) ? 64'd1 : GEN_TABLE[row][d - 2];
        r = (a * (64'(k) + 64'd1)) % n;
        return shift + 32'((r << 32) / n);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    assign pending_coords = coord_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_points <= '0;
            for (int i = 0; i < NDIM; i++) shifts[i] <= '0;
            coord_queue.delete();
            error_count = 0;
            coords_seen <= 0;
        end
        else
        begin
            if (cfg_we) min_points <= cfg_wdata;
            if (in_valid && !in_stall)
            begin
                if (kind == lrpg_pkg::KIND_LOAD)
                begin
                    if (dim_select < NDIM) shifts[dim_select] <= shift_value;
                end
                else
                begin
                    for (int d = 0; d < NDIM; d++)
                        coord_queue.push_back('{lrpg_pkg::DIM_W'(d),
                            lattice_coord(min_points, shifts[d], point_index, d),
                            d == NDIM - 1});
                end
            end
            if (out_valid && !out_stall)
            begin
                coords_seen <= coords_seen + 1;
                if (coord_queue.size() == 0)
                begin
                    report_mismatch("unexpected coordinate", coordinate, 0);
                end
                else
                begin
                    coord_t want;
                    want = coord_queue.pop_front();
                    if (dim_index !== want.dim)
                        report_mismatch("dim_index", dim_index, want.dim);
                    if (coordinate !== want.coord)
                        report_mismatch("coordinate", coordinate, want.coord);
                    if (last_coord !== want.last)
                        report_mismatch("last_coord", last_coord, want.last);
                end
            end
        end
    end
endmodule

@@ verif/lattice_rule_point_generator_test.sv @@
module lattice_rule_point_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 800;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [lrpg_pkg::REQ_W-1:0]   cfg_wdata = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         kind = lrpg_pkg::KIND_LOAD;
    logic [lrpg_pkg::INDEX_W-1:0] point_index = '0;
    logic [lrpg_pkg::DIM_W-1:0]   dim_select = '0;
    logic [lrpg_pkg::COORD_W-1:0] shift_value = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [lrpg_pkg::DIM_W-1:0]   dim_index;
    logic [lrpg_pkg::COORD_W-1:0] coordinate;
    logic                         last_coord;
    int                           error_count, pending_coords, coords_seen;
    int                           cycle_count = 0;
    int                           send_idle_pct = 0;
    int                           recv_idle_pct = 0;
    int                           points_sent = 0;
    int                           loads_sent = 0;

    always #10 clk = ~clk;

    lattice_rule_point_generator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .point_index(point_index), .dim_select(dim_select), .shift_value(shift_value),
        .out_valid(out_valid), .out_stall(out_stall), .dim_index(dim_index),
        .coordinate(coordinate), .last_coord(last_coord)
    );

    lattice_rule_point_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .point_index(point_index), .dim_select(dim_select), .shift_value(shift_value),
        .out_valid(out_valid), .out_stall(out_stall), .dim_index(dim_index),
        .coordinate(coordinate), .last_coord(last_coord),
        .error_count(error_count), .pending_coords(pending_coords),
        .coords_seen(coords_seen)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("lattice_rule_point_generator_test: done, errors");
            $finish;
        end
    end

    // Receiver: stall at random with the current idle percentage.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Drive one input transaction; sender gaps come before valid rises.
    task automatic send_item(input logic k, input logic [lrpg_pkg::INDEX_W-1:0] idx,
                             input logic [lrpg_pkg::DIM_W-1:0] dsel,
                             input logic [lrpg_pkg::COORD_W-1:0] sval);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        point_index <= idx;
        dim_select <= dsel;
        shift_value <= sval;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (k == lrpg_pkg::KIND_GENERATE) points_sent++;
        else loads_sent++;
    endtask

    // Drop valid, wait for every coordinate, then let the block settle.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_coords != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_request(input logic [lrpg_pkg::REQ_W-1:0] req);
        cfg_we <= 1'b1;
        cfg_wdata <= req;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // A quarter of random points use small indices; a quarter hit an end of the range.
    function automatic logic [lrpg_pkg::INDEX_W-1:0] pick_index;
        case ($urandom_range(3))
            0: return lrpg_pkg::INDEX_W'($urandom_range(999999999));
            1: return lrpg_pkg::INDEX_W'($urandom);
            2: return lrpg_pkg::INDEX_W'($urandom_range(20000));
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    task automatic random_phase(input int count, input int sidle, input int ridle,
                                input logic [lrpg_pkg::REQ_W-1:0] req);
        drain();
        write_request(req);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 60)
                send_item(lrpg_pkg::KIND_GENERATE, pick_index(),
                          lrpg_pkg::DIM_W'($urandom), $urandom);
            else
                send_item(lrpg_pkg::KIND_LOAD, pick_index(),
                          lrpg_pkg::DIM_W'($urandom), $urandom);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero request, reset shifts, index extremes.
        send_idle_pct = 25;
        recv_idle_pct = 76;
        send_item(lrpg_pkg::KIND_GENERATE, '0, '0, '0);
        send_item(lrpg_pkg::KIND_GENERATE, '1, '1, '1);
        // Load dimensions 0, 9 and 5 with extremes; out-of-range dimensions are ignored.
        send_item(lrpg_pkg::KIND_LOAD, '0, 4'd0, 32'hFFFF_FFFF);
        send_item(lrpg_pkg::KIND_LOAD, '0, 4'd9, 32'h8000_0000);
        send_item(lrpg_pkg::KIND_LOAD, '1, 4'd10, 32'h1234_5678);
        send_item(lrpg_pkg::KIND_LOAD, '1, 4'd15, 32'hFFFF_FFFF);
        send_item(lrpg_pkg::KIND_LOAD, '0, 4'd5, 32'h0000_0001);
        send_item(lrpg_pkg::KIND_GENERATE, 30'd10006, '0, '0);
        send_item(lrpg_pkg::KIND_GENERATE, 30'd999999999, '0, '0);
        drain();
        write_request(30'd10007);
        send_item(lrpg_pkg::KIND_GENERATE, 30'd1, '0, '0);
        drain();
        write_request(30'd10008);
        send_item(lrpg_pkg::KIND_GENERATE, 30'd20010, '0, '0);
        drain();
        // Request above every modulus saturates to the last row.
        write_request('1);
        send_item(lrpg_pkg::KIND_GENERATE, 30'd999999999, '0, '0);
        send_item(lrpg_pkg::KIND_GENERATE, 30'd123456, '0, '0);
        drain();
        write_request(30'd1000000000);
        send_item(lrpg_pkg::KIND_GENERATE, 30'd999999998, '0, '0);
        drain();
        write_request(30'd10000019);
        send_item(lrpg_pkg::KIND_GENERATE, 30'd77, '0, '0);

        // Random phases across sender/receiver idle mixes and table rows.
        random_phase(70, 25, 76, '0);
        random_phase(70, 76, 25, lrpg_pkg::REQ_W'($urandom_range(10000019)));
        random_phase(70, 0, 0, lrpg_pkg::REQ_W'($urandom_range(1000000000)));
        random_phase(70, 25, 76, '1);
        random_phase(70, 76, 25, lrpg_pkg::REQ_W'($urandom_range(3000000)));
        random_phase(60, 0, 0, lrpg_pkg::REQ_W'($urandom_range(200000)));

        drain();
        $display("covered %0d points and %0d shift loads, %0d coordinates checked",
                 points_sent, loads_sent, coords_seen);
        $display("request settings from zero through saturation, three idle mixes");
        if (error_count == 0)
            $display("lattice_rule_point_generator_test: done, clean");
        else
            $display("lattice_rule_point_generator_test: done, errors");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/lrpg_pkg.sv
rtl/lrpg_mulmod.sv
rtl/lrpg_fracdiv.sv
rtl/lattice_rule_point_generator.sv
verif/lattice_rule_point_checker.sv
verif/lattice_rule_point_generator_test.sv
